// ----- src/gzip_header_parser_macros.svh -----
// assertion macros for the gzip header parser
`ifndef GZIP_HEADER_PARSER_MACROS_SVH
`define GZIP_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define GHP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ghp_pkg.sv -----
// types and constants shared by the gzip header parser
package ghp_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [2:0] err_cause;
        logic       out_last;
    } t_out;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PAY = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_MAGIC    = 3'd1;
    localparam logic [2:0] CAUSE_METHOD   = 3'd2;
    localparam logic [2:0] CAUSE_RESERVED = 3'd3;
    localparam logic [2:0] CAUSE_TRUNC    = 3'd4;

    localparam logic [7:0] BYTE_MAGIC0    = 8'h1f;
    localparam logic [7:0] BYTE_MAGIC1    = 8'h8b;
    localparam logic [7:0] BYTE_DEFLATE   = 8'h08;
    localparam logic [7:0] FLG_RSVD_MASK  = 8'he0;

    // option bits taken from flag byte bits 4:1
    localparam int OPT_HCRC    = 0;
    localparam int OPT_EXTRA   = 1;
    localparam int OPT_NAME    = 2;
    localparam int OPT_COMMENT = 3;

    localparam logic [15:0] FIXED_SKIP = 16'd6;
    localparam logic [15:0] HCRC_SKIP  = 16'd2;

endpackage

// ----- src/gzip_header_parser.sv -----
// gzip member header parser top level with output register and skid stage
//
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   i_in  (in_byte, in_last)
// out      output     o_out_valid / i_out_stall o_out (kind, byte, cause, last)
//
// one transaction per cycle while o_in_stall is low; its result is registered
// the rate is set by the combinational phase decode in ghp_parse
// synchronous active-low reset returns to awaiting the first magic byte
// a stalled output parks one more result in the skid stage, then o_in_stall rises
// o_in_stall comes from a register and does not depend on i_out_stall
module gzip_header_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ghp_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ghp_pkg::t_out o_out
);
    import ghp_pkg::*;

    t_out r_out;
    t_out r_skid;
    logic r_out_valid;
    logic r_skid_valid;
    t_out res;
    logic in_fire;
    logic out_fire;

    assign in_fire  = i_in_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_out_stall;

    ghp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_in    (i_in),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (in_fire) begin
                r_out <= res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (!r_out_valid) begin
            if (in_fire) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end
        end else if (in_fire) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`include "gzip_header_parser_macros.svh"

    `GHP_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with empty output")
    `GHP_ASSERT_NOW(a_cause_on_error, r_out_valid, ((r_out.out_kind == KIND_ERR) == (r_out.err_cause != CAUSE_NONE)), "cause disagrees with kind")
    `GHP_ASSERT_NOW(a_byte_only_payload, r_out_valid && r_out.out_kind != KIND_PAY, r_out.out_byte == 8'd0, "byte set outside payload")
    `GHP_ASSERT_NEXT(a_skid_fill, r_out_valid && i_out_stall && !r_skid_valid && i_in_valid, r_skid_valid, "stalled transaction lost")

endmodule

// ----- src/ghp_parse.sv -----
// header phase tracking and per-byte result decode
module ghp_parse (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  ghp_pkg::t_in  i_in,
    output ghp_pkg::t_out o_res
);
    import ghp_pkg::*;

    typedef enum logic [12:0] {
        PH_MAGIC0  = 13'b0000000000001,
        PH_MAGIC1  = 13'b0000000000010,
        PH_METHOD  = 13'b0000000000100,
        PH_FLAGS   = 13'b0000000001000,
        PH_FIXED6  = 13'b0000000010000,
        PH_XLEN_LO = 13'b0000000100000,
        PH_XLEN_HI = 13'b0000001000000,
        PH_XDATA   = 13'b0000010000000,
        PH_NAME    = 13'b0000100000000,
        PH_COMMENT = 13'b0001000000000,
        PH_HCRC    = 13'b0010000000000,
        PH_PAYLOAD = 13'b0100000000000,
        PH_ERROR   = 13'b1000000000000
    } t_phase;

    typedef enum logic [1:0] {
        SEC_EXTRA   = 2'd0,
        SEC_NAME    = 2'd1,
        SEC_COMMENT = 2'd2,
        SEC_HCRC    = 2'd3
    } t_sec;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_flags, n_flags;
    logic [15:0] r_skip, n_skip;
    logic [2:0]  r_cause, n_cause;

    logic [2:0]  cause;
    logic [1:0]  kind;
    logic [7:0]  obyte;
    logic [15:0] skip_dec;
    logic [15:0] xlen;
    logic        is_hdr;
    logic [7:0]  b;
    logic        last;

    // first optional section at or after start that the flags ask for
    function automatic t_phase next_section(input t_sec start, input logic [3:0] flags);
        t_phase ph;
        ph = PH_PAYLOAD;
        if (start <= SEC_HCRC && flags[OPT_HCRC])
            ph = PH_HCRC;
        if (start <= SEC_COMMENT && flags[OPT_COMMENT])
            ph = PH_COMMENT;
        if (start <= SEC_NAME && flags[OPT_NAME])
            ph = PH_NAME;
        if (start == SEC_EXTRA && flags[OPT_EXTRA])
            ph = PH_XLEN_LO;
        return ph;
    endfunction

    assign b        = i_in.in_byte;
    assign last     = i_in.in_last;
    assign skip_dec = r_skip - 16'd1;
    assign xlen     = r_skip | {b, 8'd0};

    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        n_skip  = r_skip;
        n_cause = r_cause;
        cause   = CAUSE_NONE;
        kind    = KIND_HDR;
        obyte   = 8'd0;
        is_hdr  = 1'b1;
        case (r_phase)
            PH_MAGIC1: begin
                if (b != BYTE_MAGIC1) cause = CAUSE_MAGIC;
                else n_phase = PH_METHOD;
            end
            PH_METHOD: begin
                if (b != BYTE_DEFLATE) cause = CAUSE_METHOD;
                else n_phase = PH_FLAGS;
            end
            PH_FLAGS: begin
                if ((b & FLG_RSVD_MASK) != 8'd0) begin
                    cause = CAUSE_RESERVED;
                end else begin
                    n_flags = b[4:1];
                    n_skip  = FIXED_SKIP;
                    n_phase = PH_FIXED6;
                end
            end
            PH_FIXED6: begin
                n_skip  = skip_dec;
                n_phase = (skip_dec == 16'd0) ? next_section(SEC_EXTRA, r_flags) : PH_FIXED6;
            end
            PH_XLEN_LO: begin
                n_skip  = {8'd0, b};
                n_phase = PH_XLEN_HI;
            end
            PH_XLEN_HI: begin
                n_skip  = xlen;
                n_phase = (xlen == 16'd0) ? next_section(SEC_NAME, r_flags) : PH_XDATA;
            end
            PH_XDATA: begin
                n_skip  = skip_dec;
                n_phase = (skip_dec == 16'd0) ? next_section(SEC_NAME, r_flags) : PH_XDATA;
            end
            PH_NAME: begin
                if (b == 8'd0) n_phase = next_section(SEC_COMMENT, r_flags);
            end
            PH_COMMENT: begin
                if (b == 8'd0) n_phase = next_section(SEC_HCRC, r_flags);
            end
            PH_HCRC: begin
                n_skip  = skip_dec;
                n_phase = (skip_dec == 16'd0) ? PH_PAYLOAD : PH_HCRC;
            end
            PH_PAYLOAD: begin
                is_hdr = 1'b0;
                kind   = KIND_PAY;
                obyte  = b;
            end
            PH_ERROR: begin
                is_hdr = 1'b0;
                cause  = r_cause;
            end
            default: begin
                // magic0 and any unused code
                if (b != BYTE_MAGIC0) cause = CAUSE_MAGIC;
                else n_phase = PH_MAGIC1;
            end
        endcase

        // entering the header crc loads its byte count
        if (n_phase == PH_HCRC && r_phase != PH_HCRC)
            n_skip = HCRC_SKIP;

        if (is_hdr && cause == CAUSE_NONE && last)
            cause = CAUSE_TRUNC;

        if (r_phase == PH_ERROR || cause != CAUSE_NONE) begin
            kind    = KIND_ERR;
            obyte   = 8'd0;
            n_cause = cause;
            n_phase = PH_ERROR;
        end

        o_res.out_kind  = kind;
        o_res.out_byte  = obyte;
        o_res.err_cause = (kind == KIND_ERR) ? n_cause : CAUSE_NONE;
        o_res.out_last  = last;

        if (last) begin
            n_phase = PH_MAGIC0;
            n_cause = CAUSE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC0;
            r_flags <= 4'd0;
            r_skip  <= 16'd0;
            r_cause <= CAUSE_NONE;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_skip  <= n_skip;
            r_cause <= n_cause;
        end
    end

endmodule
